// ----- rtl/core/tlc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlc_pkg
// Shared types, register codes and address split for the two-level cache.
// ---------------------------------------------------------------------------
package tlc_pkg;

	localparam int NEAR_SETS  = 64;
	localparam int NEAR_WAYS  = 4;
	localparam int FAR_SETS   = 256;
	localparam int FAR_WAYS   = 8;
	localparam int ADDR_W     = 32;
	localparam int NEAR_SET_W = $clog2(NEAR_SETS);
	localparam int FAR_SET_W  = $clog2(FAR_SETS);
	localparam int NEAR_AGE_W = $clog2(NEAR_WAYS);
	localparam int FAR_AGE_W  = $clog2(FAR_WAYS);
	localparam int WAY_IDX_W  = $clog2(FAR_WAYS);
	localparam int WAY_CNT_W  = WAY_IDX_W + 1;
	localparam int CFG_ADDR_W = 5;
	localparam int CNT_W      = 32;

	localparam logic [2:0] REG_BLOCK_BITS     = 3'd0;
	localparam logic [2:0] REG_L1_SIZE_BITS   = 3'd1;
	localparam logic [2:0] REG_L1_WAY_BITS    = 3'd2;
	localparam logic [2:0] REG_L2_SIZE_BITS   = 3'd3;
	localparam logic [2:0] REG_L2_WAY_BITS    = 3'd4;
	localparam logic [2:0] REG_WRITE_ALLOCATE = 3'd5;

	typedef struct packed {
		logic [2:0] block_bits;
		logic [4:0] l1_size_bits;
		logic [1:0] l1_way_bits;
		logic [4:0] l2_size_bits;
		logic [1:0] l2_way_bits;
		logic       write_allocate;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0]     tag;
		logic [ADDR_W-1:0]     line;
		logic                  valid;
		logic                  dirty;
		logic [NEAR_AGE_W-1:0] age;
	} near_way_t;

	typedef struct packed {
		logic [ADDR_W-1:0]    tag;
		logic [ADDR_W-1:0]    line;
		logic                 valid;
		logic                 dirty;
		logic [FAR_AGE_W-1:0] age;
	} way_t;

	typedef near_way_t [NEAR_WAYS-1:0] near_row_t;
	typedef way_t [FAR_WAYS-1:0] row_t;

	typedef struct packed {
		logic [FAR_SET_W-1:0] set;
		logic [ADDR_W-1:0]    tag;
		logic [WAY_CNT_W-1:0] ways;
	} split_t;

	typedef struct packed {
		logic              hit;
		logic              vic_valid;
		logic              vic_dirty;
		logic [ADDR_W-1:0] vic_line;
	} unit_stat_t;

	// Set index, tag and active way count of an address at one level.
	function automatic split_t split_addr(input logic lvl_far, input cfg_t c,
			input logic [ADDR_W-1:0] a);
		logic [2:0] bb;
		logic [1:0] wb;
		logic [4:0] sz;
		logic [5:0] lim;
		logic [5:0] sum;
		logic [5:0] sb;
		logic [4:0] sh;
		split_t r;
		bb  = c.block_bits;
		wb  = lvl_far ? c.l2_way_bits : c.l1_way_bits;
		sz  = lvl_far ? c.l2_size_bits : c.l1_size_bits;
		lim = lvl_far ? 6'(FAR_SET_W) : 6'(NEAR_SET_W);
		sum = 6'(bb) + 6'(wb);
		if (6'(sz) <= sum) begin
			sb = '0;
		end else begin
			sb = 6'(sz) - sum;
		end
		if (sb > lim) begin
			sb = lim;
		end
		sh = 5'(bb) + sb[4:0];
		r.tag = a >> sh;
		r.set = FAR_SET_W'((a >> bb) & ((32'd1 << sb[3:0]) - 32'd1));
		if (lvl_far) begin
			r.ways = WAY_CNT_W'(1) << wb;
		end else if (wb >= 2'(NEAR_AGE_W)) begin
			r.ways = WAY_CNT_W'(NEAR_WAYS);
		end else begin
			r.ways = WAY_CNT_W'(1) << wb;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tlc_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlc_req_if
// Access request channel: opcode and byte address.
// ---------------------------------------------------------------------------
interface tlc_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] address;
	modport source(output valid, opcode, address, input ready);
	modport sink(input valid, opcode, address, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tlc_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlc_rsp_if
// Access result channel: hit flags and running counters.
// ---------------------------------------------------------------------------
interface tlc_rsp_if;
	logic        valid;
	logic        ready;
	logic        l1_hit;
	logic        l2_hit;
	logic        memory_access;
	logic [31:0] l1_hit_count;
	logic [31:0] l1_miss_count;
	logic [31:0] l2_hit_count;
	logic [31:0] l2_miss_count;
	modport source(output valid, l1_hit, l2_hit, memory_access, l1_hit_count,
		l1_miss_count, l2_hit_count, l2_miss_count, input ready);
	modport sink(input valid, l1_hit, l2_hit, memory_access, l1_hit_count,
		l1_miss_count, l2_hit_count, l2_miss_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tlc_row_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlc_row_unit
// Shared set unit: lookup, victim choice, LRU touch, fill and invalidate
// on one set row of either level.
// ---------------------------------------------------------------------------
module tlc_row_unit (
	input  tlc_pkg::row_t                    row_i,
	input  logic [tlc_pkg::WAY_CNT_W-1:0]    ways,
	input  logic [tlc_pkg::ADDR_W-1:0]       tag,
	input  logic [tlc_pkg::ADDR_W-1:0]       line,
	input  logic                             mark,
	output tlc_pkg::row_t                    acc_row,
	output tlc_pkg::row_t                    fill_row,
	output tlc_pkg::row_t                    inval_row,
	output tlc_pkg::unit_stat_t              stat
);
	import tlc_pkg::*;

	logic                 hit;
	logic [WAY_IDX_W-1:0] hit_way;
	logic                 found_inv;
	logic [WAY_IDX_W-1:0] inv_way;
	logic [WAY_IDX_W-1:0] old_way;
	logic [WAY_IDX_W-1:0] vic;
	row_t                 tmp_acc;
	row_t                 tmp_fill;

	function automatic row_t touch_row(input row_t r, input logic [WAY_IDX_W-1:0] way,
			input logic [WAY_CNT_W-1:0] n);
		row_t t;
		logic [FAR_AGE_W-1:0] old;
		t   = r;
		old = r[way].age;
		for (int w = 0; w < FAR_WAYS; w++) begin
			if (WAY_CNT_W'(w) < n && WAY_IDX_W'(w) != way && r[w].age > old) begin
				t[w].age = r[w].age - FAR_AGE_W'(1);
			end
		end
		t[way].age = FAR_AGE_W'(n - WAY_CNT_W'(1));
		return t;
	endfunction

	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		found_inv = 1'b0;
		inv_way   = '0;
		old_way   = '0;
		for (int w = 0; w < FAR_WAYS; w++) begin
			if (WAY_CNT_W'(w) < ways) begin
				if (!hit && row_i[w].valid && row_i[w].tag == tag) begin
					hit     = 1'b1;
					hit_way = WAY_IDX_W'(w);
				end
				if (!found_inv && !row_i[w].valid) begin
					found_inv = 1'b1;
					inv_way   = WAY_IDX_W'(w);
				end
				if (row_i[w].age < row_i[old_way].age) begin
					old_way = WAY_IDX_W'(w);
				end
			end
		end
		vic = found_inv ? inv_way : old_way;
	end

	always_comb begin
		tmp_acc = row_i;
		tmp_acc[hit_way].dirty = row_i[hit_way].dirty | mark;
		acc_row = hit ? touch_row(tmp_acc, hit_way, ways) : row_i;

		tmp_fill = row_i;
		tmp_fill[vic].tag   = tag;
		tmp_fill[vic].line  = line;
		tmp_fill[vic].valid = 1'b1;
		tmp_fill[vic].dirty = mark;
		fill_row = touch_row(tmp_fill, vic, ways);

		// back-invalidate: older ways move up to close the gap
		inval_row = row_i;
		if (hit) begin
			for (int w = 0; w < FAR_WAYS; w++) begin
				if (WAY_CNT_W'(w) < ways && row_i[w].age < row_i[hit_way].age) begin
					inval_row[w].age = row_i[w].age + FAR_AGE_W'(1);
				end
			end
			inval_row[hit_way].valid = 1'b0;
			inval_row[hit_way].age   = '0;
		end
	end

	assign stat.hit       = hit;
	assign stat.vic_valid = row_i[vic].valid;
	assign stat.vic_dirty = row_i[vic].dirty;
	assign stat.vic_line  = row_i[vic].line;

endmodule
`default_nettype wire

// ----- rtl/core/two_level_inclusive_cache_lru.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// two_level_inclusive_cache_lru
// Tag side of an inclusive two-level write-back cache with LRU ages.
// ---------------------------------------------------------------------------
// Each access is accepted, then visits one or more set rows (memory read,
// then update through the shared set unit and write back) and ends with a
// state that posts the result. A first-level hit visits one row; the worst
// case, a double miss with a back-invalidation and a dirty first-level
// victim, visits five rows. After reset a clearing pass initializes both tag
// memories, one set row per cycle, before the first access is taken;
// configuration writes are taken during the pass.
module two_level_inclusive_cache_lru (
	input  logic                              clk,
	input  logic                              arst_n,
	tlc_req_if.sink                           req,
	tlc_rsp_if.source                         rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tlc_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import tlc_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_EV    = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [2:0] STEP_NEAR_LOOK  = 3'd0;
	localparam logic [2:0] STEP_FAR_LOOK   = 3'd1;
	localparam logic [2:0] STEP_NEAR_INVAL = 3'd2;
	localparam logic [2:0] STEP_NEAR_FILL  = 3'd3;
	localparam logic [2:0] STEP_FAR_DIRTY  = 3'd4;

	logic [2:0]           state_q;
	logic [2:0]           step_q;
	cfg_t                 cfg_q;
	logic                 write_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    vline_q;
	split_t               sp_q;
	logic [FAR_SET_W-1:0] clr_q;
	logic                 h1_q, h2_q, mem_q;
	logic [CNT_W-1:0]     l1h_q, l1m_q, l2h_q, l2m_q;
	logic                 out_valid_q;
	logic                 o_h1_q, o_h2_q, o_mem_q;
	logic [CNT_W-1:0]     o_l1h_q, o_l1m_q, o_l2h_q, o_l2m_q;

	near_row_t            near_mem [NEAR_SETS];
	row_t                 far_mem [FAR_SETS];
	near_row_t            near_rd_q;
	row_t                 far_rd_q;

	logic                  step_far;
	logic [ADDR_W-1:0]     op_addr;
	split_t                sp_next;
	logic                  alloc;
	row_t                  unit_row;
	row_t                  acc_row, fill_row, inval_row;
	unit_stat_t            stat;
	logic                  near_we, far_we;
	logic [NEAR_SET_W-1:0] near_wa;
	logic [FAR_SET_W-1:0]  far_wa;
	near_row_t             near_wd;
	row_t                  far_wd;
	near_row_t             near_clr;
	row_t                  far_clr;
	logic                  cfg_wr;

	function automatic near_row_t to_near(input row_t r);
		near_row_t n;
		for (int w = 0; w < NEAR_WAYS; w++) begin
			n[w].tag   = r[w].tag;
			n[w].line  = r[w].line;
			n[w].valid = r[w].valid;
			n[w].dirty = r[w].dirty;
			n[w].age   = r[w].age[NEAR_AGE_W-1:0];
		end
		return n;
	endfunction

	function automatic row_t from_near(input near_row_t n);
		row_t r;
		r = '0;
		for (int w = 0; w < NEAR_WAYS; w++) begin
			r[w].tag   = n[w].tag;
			r[w].line  = n[w].line;
			r[w].valid = n[w].valid;
			r[w].dirty = n[w].dirty;
			r[w].age   = FAR_AGE_W'(n[w].age);
		end
		return r;
	endfunction

	assign step_far = (step_q == STEP_FAR_LOOK) || (step_q == STEP_FAR_DIRTY);
	assign op_addr  = ((step_q == STEP_NEAR_INVAL) || (step_q == STEP_FAR_DIRTY)) ?
		vline_q : addr_q;
	assign sp_next  = split_addr(step_far, cfg_q, op_addr);
	assign alloc    = !write_q || cfg_q.write_allocate;
	assign unit_row = step_far ? far_rd_q : from_near(near_rd_q);

	tlc_row_unit u_row_unit (
		.row_i     (unit_row),
		.ways      (sp_q.ways),
		.tag       (sp_q.tag),
		.line      (addr_q),
		.mark      ((step_q == STEP_FAR_DIRTY) ? 1'b1 : write_q),
		.acc_row   (acc_row),
		.fill_row  (fill_row),
		.inval_row (inval_row),
		.stat      (stat)
	);

	// reset image of a row: empty, ages equal to way index
	always_comb begin
		near_clr = '0;
		far_clr  = '0;
		for (int w = 0; w < NEAR_WAYS; w++) begin
			near_clr[w].age = NEAR_AGE_W'(w);
		end
		for (int w = 0; w < FAR_WAYS; w++) begin
			far_clr[w].age = FAR_AGE_W'(w);
		end
	end

	always_comb begin
		near_we = 1'b0;
		far_we  = 1'b0;
		near_wa = sp_q.set[NEAR_SET_W-1:0];
		far_wa  = sp_q.set;
		near_wd = to_near(acc_row);
		far_wd  = acc_row;
		if (state_q == ST_CLEAR) begin
			near_we = clr_q < FAR_SET_W'(NEAR_SETS);
			far_we  = 1'b1;
			near_wa = clr_q[NEAR_SET_W-1:0];
			far_wa  = clr_q;
			near_wd = near_clr;
			far_wd  = far_clr;
		end else if (state_q == ST_EV) begin
			unique case (step_q)
				STEP_NEAR_LOOK: begin
					near_we = stat.hit;
				end
				STEP_FAR_LOOK: begin
					far_we = stat.hit || alloc;
					far_wd = stat.hit ? acc_row : fill_row;
				end
				STEP_NEAR_INVAL: begin
					near_we = 1'b1;
					near_wd = to_near(inval_row);
				end
				STEP_NEAR_FILL: begin
					near_we = 1'b1;
					near_wd = to_near(fill_row);
				end
				STEP_FAR_DIRTY: begin
					far_we = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (near_we) begin
			near_mem[near_wa] <= near_wd;
		end
		if (state_q == ST_RD) begin
			near_rd_q <= near_mem[sp_next.set[NEAR_SET_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (far_we) begin
			far_mem[far_wa] <= far_wd;
		end
		if (state_q == ST_RD) begin
			far_rd_q <= far_mem[sp_next.set];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			sp_q <= sp_next;
		end
		if (req.valid && req.ready) begin
			write_q <= req.opcode;
			addr_q  <= req.address;
		end
		if (state_q == ST_EV) begin
			if (step_q == STEP_FAR_LOOK || step_q == STEP_NEAR_FILL) begin
				vline_q <= stat.vic_line;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= STEP_NEAR_LOOK;
			clr_q   <= '0;
			h1_q    <= 1'b0;
			h2_q    <= 1'b0;
			mem_q   <= 1'b0;
			l1h_q   <= '0;
			l1m_q   <= '0;
			l2h_q   <= '0;
			l2m_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + FAR_SET_W'(1);
					if (clr_q == FAR_SET_W'(FAR_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_RD;
						step_q  <= STEP_NEAR_LOOK;
						h1_q    <= 1'b0;
						h2_q    <= 1'b0;
						mem_q   <= 1'b0;
					end
				end
				ST_RD: begin
					state_q <= ST_EV;
				end
				ST_EV: begin
					state_q <= ST_DONE;
					unique case (step_q)
						STEP_NEAR_LOOK: begin
							if (stat.hit) begin
								h1_q <= 1'b1;
								if (l1h_q != '1) l1h_q <= l1h_q + CNT_W'(1);
							end else begin
								if (l1m_q != '1) l1m_q <= l1m_q + CNT_W'(1);
								step_q  <= STEP_FAR_LOOK;
								state_q <= ST_RD;
							end
						end
						STEP_FAR_LOOK: begin
							if (stat.hit) begin
								h2_q <= 1'b1;
								if (l2h_q != '1) l2h_q <= l2h_q + CNT_W'(1);
								if (alloc) begin
									step_q  <= STEP_NEAR_FILL;
									state_q <= ST_RD;
								end
							end else begin
								mem_q <= 1'b1;
								if (l2m_q != '1) l2m_q <= l2m_q + CNT_W'(1);
								if (alloc) begin
									step_q  <= stat.vic_valid ? STEP_NEAR_INVAL : STEP_NEAR_FILL;
									state_q <= ST_RD;
								end
							end
						end
						STEP_NEAR_INVAL: begin
							step_q  <= STEP_NEAR_FILL;
							state_q <= ST_RD;
						end
						STEP_NEAR_FILL: begin
							// dirty victim hands its dirt to the second level
							if (stat.vic_valid && stat.vic_dirty) begin
								step_q  <= STEP_FAR_DIRTY;
								state_q <= ST_RD;
							end
						end
						STEP_FAR_DIRTY: begin
							state_q <= ST_DONE;
						end
						default: begin
						end
					endcase
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
			o_h1_q  <= h1_q;
			o_h2_q  <= h2_q;
			o_mem_q <= mem_q;
			o_l1h_q <= l1h_q;
			o_l1m_q <= l1m_q;
			o_l2h_q <= l2h_q;
			o_l2m_q <= l2m_q;
		end
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.l1_hit        = o_h1_q;
	assign rsp.l2_hit        = o_h2_q;
	assign rsp.memory_access = o_mem_q;
	assign rsp.l1_hit_count  = o_l1h_q;
	assign rsp.l1_miss_count = o_l1m_q;
	assign rsp.l2_hit_count  = o_l2h_q;
	assign rsp.l2_miss_count = o_l2m_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_bits     <= 3'd4;
			cfg_q.l1_size_bits   <= 5'd10;
			cfg_q.l1_way_bits    <= 2'd1;
			cfg_q.l2_size_bits   <= 5'd12;
			cfg_q.l2_way_bits    <= 2'd2;
			cfg_q.write_allocate <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_BLOCK_BITS:     cfg_q.block_bits     <= pwdata[2:0];
				REG_L1_SIZE_BITS:   cfg_q.l1_size_bits   <= pwdata[4:0];
				REG_L1_WAY_BITS:    cfg_q.l1_way_bits    <= pwdata[1:0];
				REG_L2_SIZE_BITS:   cfg_q.l2_size_bits   <= pwdata[4:0];
				REG_L2_WAY_BITS:    cfg_q.l2_way_bits    <= pwdata[1:0];
				REG_WRITE_ALLOCATE: cfg_q.write_allocate <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_BLOCK_BITS:     prdata = 32'(cfg_q.block_bits);
			REG_L1_SIZE_BITS:   prdata = 32'(cfg_q.l1_size_bits);
			REG_L1_WAY_BITS:    prdata = 32'(cfg_q.l1_way_bits);
			REG_L2_SIZE_BITS:   prdata = 32'(cfg_q.l2_size_bits);
			REG_L2_WAY_BITS:    prdata = 32'(cfg_q.l2_way_bits);
			REG_WRITE_ALLOCATE: prdata = 32'(cfg_q.write_allocate);
			default:            prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/tlc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlc_checker
// Port-level checks on the result channel and configuration port.
// ---------------------------------------------------------------------------
module tlc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        l1_hit,
	input logic        l2_hit,
	input logic        memory_access,
	input logic [31:0] l1_miss_count,
	input logic [31:0] l2_hit_count,
	input logic [31:0] l2_miss_count,
	input logic        pready
);

	// exactly one level serves each access
	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot({l1_hit, l2_hit, memory_access}))
		else $error("result flags not one-hot");

	// a second-level outcome implies a counted first-level miss and, for a hit, a counted second-level hit
	a_l2_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (l2_hit || memory_access) |->
			l1_miss_count != 32'd0 && (!l2_hit || l2_hit_count != 32'd0))
		else $error("first-level miss not counted");

	a_mem_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && memory_access |-> l2_miss_count != 32'd0)
		else $error("memory access not counted");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped before taken");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind two_level_inclusive_cache_lru tlc_checker u_tlc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.l1_hit        (rsp.l1_hit),
	.l2_hit        (rsp.l2_hit),
	.memory_access (rsp.memory_access),
	.l1_miss_count (rsp.l1_miss_count),
	.l2_hit_count  (rsp.l2_hit_count),
	.l2_miss_count (rsp.l2_miss_count),
	.pready        (pready)
);
`default_nettype wire
